// ===== src/ntpoc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpoc_pkg
// Shared types and constants for the NTP clock offset corrector.
// ----------------------------------------------------------------------------
package ntpoc_pkg;

    // Seconds between the NTP era origin (1900) and the Unix epoch (1970).
    localparam logic [31:0] NTP_UNIX_DIFF = 32'd2208988800;

    // Fraction units (2^-32 s) per millisecond, truncated.
    localparam logic [22:0] MS_DIVISOR = 23'd4294967;

    // Scale used for the first millisecond estimate: frac * 1000 / 2^32.
    localparam logic [9:0]  MS_SCALE   = 10'd1000;

    localparam int unsigned STEP_W = 8;
    localparam int unsigned SLEW_W = 10;

    localparam logic [7:0] STEP_RESET = 8'd1;
    localparam logic [9:0] SLEW_RESET = 10'd100;

    typedef enum logic [0:0] {
        CFG_STEP_THRESHOLD = 1'b0,
        CFG_SLEW_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_REJECT = 2'd0,
        ACT_STEP   = 2'd1,
        ACT_SLEW   = 2'd2,
        ACT_HOLD   = 2'd3
    } action_t;

endpackage

// ===== src/ntp_clock_offset_corrector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_clock_offset_corrector
// Pipelined NTP reply evaluation: server time estimate, offset and decision.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------
// request  | in        | s_tvalid/s_tready  | s_tdata: T1, T2, T3 (NTP), T4
// result   | out       | m_tvalid/m_tready  | m_tdata: action, offset, estimate
// config   | in        | cfg_wr_en          | cfg_addr, cfg_wdata (no wait)
//
// The datapath is an eight-stage pipeline; every request produces exactly one
// result, which passes through the stage registers in order and waits in stage 8 while m_tready is low.
// One request is accepted per cycle while the pipeline is not stalled.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads the
// default thresholds; requests are accepted once reset is released.
// Each stage holds while the stage after it is full and stalled, so a bubble
// anywhere in the pipe is filled even while a finished result waits.
//
// Stages:
//   1  NTP to Unix seconds conversion of T1..T3
//   2  validity compares, T3-T2 and T4-T1
//   3  sum of the truncated halves
//   4  estimate = T2 + halves
//   5  sign and magnitude of estimate - T4
//   6  millisecond estimate, (fraction * 1000) >> 32
//   7  remainder of the fraction after that estimate
//   8  millisecond correction, thresholds and result formatting
// ----------------------------------------------------------------------------
module ntp_clock_offset_corrector (
    input  logic         aclk,
    input  logic         aresetn,

    // Fields from bit 0 up: origin_seconds, origin_fraction, receive_seconds,
    // receive_fraction, transmit_seconds, transmit_fraction, local_seconds,
    // local_fraction (32 bits each).
    input  logic [255:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,

    // Fields from bit 0 up: action (2), server_ahead (1), offset_seconds (32),
    // offset_ms (10), new_seconds (32), new_fraction (32), slew_ms (9),
    // two zero pad bits.
    output logic [119:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,

    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [9:0]   cfg_wdata
);

    localparam int unsigned NSTG = 8;

    // ------------------------------------------------------------------------
    // Configuration registers. The user writes only while the pipeline is idle; unenforced.
    // ------------------------------------------------------------------------
    logic [ntpoc_pkg::STEP_W-1:0] step_thr_reg;
    logic [ntpoc_pkg::SLEW_W-1:0] slew_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_thr_reg <= ntpoc_pkg::STEP_RESET;
            slew_thr_reg <= ntpoc_pkg::SLEW_RESET;
        end else if (cfg_wr_en) begin
            unique case (ntpoc_pkg::cfg_index_t'(cfg_addr))
                ntpoc_pkg::CFG_STEP_THRESHOLD: begin
                    step_thr_reg <= cfg_wdata[ntpoc_pkg::STEP_W-1:0];
                end
                ntpoc_pkg::CFG_SLEW_THRESHOLD: begin
                    slew_thr_reg <= cfg_wdata[ntpoc_pkg::SLEW_W-1:0];
                end
                default: begin
                    step_thr_reg <= step_thr_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. A stage can take new data when it is empty or when
    // the stage after it moves on in the same cycle.
    // ------------------------------------------------------------------------
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] valid_next;
    logic [NSTG:1] stage_ready;
    logic [NSTG:1] prev_valid;
    logic [NSTG:1] load;

    always_comb begin
        stage_ready[NSTG] = !valid_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        prev_valid = {valid_reg[NSTG-1:1], s_tvalid};
        load       = stage_ready & prev_valid;
        valid_next = valid_reg;
        for (int k = 1; k <= NSTG; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = prev_valid[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[1];
    assign m_tvalid = valid_reg[NSTG];

    // ------------------------------------------------------------------------
    // Stage 1: move T1..T3 seconds to the Unix epoch (modulo 2^32).
    // ------------------------------------------------------------------------
    logic [63:0] t1_next, t2_next, t3_next, t4_next;
    logic [63:0] s1_t1_reg, s1_t2_reg, s1_t3_reg, s1_t4_reg;

    assign t1_next = {s_tdata[31:0]    - ntpoc_pkg::NTP_UNIX_DIFF, s_tdata[63:32]};
    assign t2_next = {s_tdata[95:64]   - ntpoc_pkg::NTP_UNIX_DIFF, s_tdata[127:96]};
    assign t3_next = {s_tdata[159:128] - ntpoc_pkg::NTP_UNIX_DIFF, s_tdata[191:160]};
    assign t4_next = {s_tdata[223:192], s_tdata[255:224]};

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            s1_t1_reg <= t1_next;
            s1_t2_reg <= t2_next;
            s1_t3_reg <= t3_next;
            s1_t4_reg <= t4_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: reply sanity check and the two round-trip differences.
    // ------------------------------------------------------------------------
    logic        ok_next;
    logic [63:0] d32_next, d41_next;
    logic        s2_ok_reg;
    logic [63:0] s2_t2_reg, s2_t4_reg, s2_d32_reg, s2_d41_reg;

    assign ok_next  = (s1_t4_reg > s1_t1_reg) && (s1_t3_reg > s1_t2_reg);
    assign d32_next = s1_t3_reg - s1_t2_reg;
    assign d41_next = s1_t4_reg - s1_t1_reg;

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            s2_ok_reg  <= ok_next;
            s2_t2_reg  <= s1_t2_reg;
            s2_t4_reg  <= s1_t4_reg;
            s2_d32_reg <= d32_next;
            s2_d41_reg <= d41_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: sum of the truncated halves, modulo 2^64.
    // ------------------------------------------------------------------------
    logic [63:0] half_sum_next;
    logic        s3_ok_reg;
    logic [63:0] s3_t2_reg, s3_t4_reg, s3_half_sum_reg;

    assign half_sum_next = (s2_d32_reg >> 1) + (s2_d41_reg >> 1);

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            s3_ok_reg       <= s2_ok_reg;
            s3_t2_reg       <= s2_t2_reg;
            s3_t4_reg       <= s2_t4_reg;
            s3_half_sum_reg <= half_sum_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: estimated server time now.
    // ------------------------------------------------------------------------
    logic [63:0] est_next;
    logic        s4_ok_reg;
    logic [63:0] s4_t4_reg, s4_est_reg;

    assign est_next = s3_t2_reg + s3_half_sum_reg;

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            s4_ok_reg  <= s3_ok_reg;
            s4_t4_reg  <= s3_t4_reg;
            s4_est_reg <= est_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: offset sign and magnitude. Both differences are formed side by
    // side and the sign picks one.
    // ------------------------------------------------------------------------
    logic        ahead_next;
    logic [63:0] mag_next;
    logic        s5_ok_reg, s5_ahead_reg;
    logic [63:0] s5_est_reg, s5_mag_reg;

    assign ahead_next = s4_est_reg > s4_t4_reg;
    assign mag_next   = ahead_next ? (s4_est_reg - s4_t4_reg) : (s4_t4_reg - s4_est_reg);

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            s5_ok_reg    <= s4_ok_reg;
            s5_ahead_reg <= ahead_next;
            s5_est_reg   <= s4_est_reg;
            s5_mag_reg   <= mag_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: first millisecond estimate. (frac * 1000) >> 32 is never above
    // the true quotient frac / 4294967 and never more than one below it.
    // ------------------------------------------------------------------------
    logic [41:0] ms_prod;
    logic        s6_ok_reg, s6_ahead_reg;
    logic [63:0] s6_est_reg;
    logic [31:0] s6_secs_reg, s6_frac_reg;
    logic [9:0]  s6_q0_reg;

    assign ms_prod = 42'(s5_mag_reg[31:0]) * 42'(ntpoc_pkg::MS_SCALE);

    always_ff @(posedge aclk) begin
        if (load[6]) begin
            s6_ok_reg    <= s5_ok_reg;
            s6_ahead_reg <= s5_ahead_reg;
            s6_est_reg   <= s5_est_reg;
            s6_secs_reg  <= s5_mag_reg[63:32];
            s6_frac_reg  <= s5_mag_reg[31:0];
            s6_q0_reg    <= ms_prod[41:32];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: remainder left after the first estimate.
    // ------------------------------------------------------------------------
    logic [32:0] q0_times_div;
    logic [31:0] rem_next;
    logic        s7_ok_reg, s7_ahead_reg;
    logic [63:0] s7_est_reg;
    logic [31:0] s7_secs_reg, s7_rem_reg;
    logic [9:0]  s7_q0_reg;

    assign q0_times_div = 33'(s6_q0_reg) * 33'(ntpoc_pkg::MS_DIVISOR);
    assign rem_next     = s6_frac_reg - q0_times_div[31:0];

    always_ff @(posedge aclk) begin
        if (load[7]) begin
            s7_ok_reg    <= s6_ok_reg;
            s7_ahead_reg <= s6_ahead_reg;
            s7_est_reg   <= s6_est_reg;
            s7_secs_reg  <= s6_secs_reg;
            s7_rem_reg   <= rem_next;
            s7_q0_reg    <= s6_q0_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 8: correct the millisecond count, take the decision and build the
    // result. A rejected reply reports zeros in every field.
    // ------------------------------------------------------------------------
    logic [9:0]           ms_next;
    ntpoc_pkg::action_t   action_next;
    logic [8:0]           slew_next;
    ntpoc_pkg::action_t   s8_action_reg;
    logic                 s8_ahead_reg;
    logic [31:0]          s8_secs_reg;
    logic [9:0]           s8_ms_reg;
    logic [63:0]          s8_est_reg;
    logic [8:0]           s8_slew_reg;

    always_comb begin
        ms_next = s7_q0_reg;
        if (s7_rem_reg >= 32'(ntpoc_pkg::MS_DIVISOR)) begin
            ms_next = s7_q0_reg + 10'd1;
        end
        slew_next = '0;
        if (!s7_ok_reg) begin
            action_next = ntpoc_pkg::ACT_REJECT;
        end else if (s7_secs_reg > 32'(step_thr_reg)) begin
            action_next = ntpoc_pkg::ACT_STEP;
        end else if (ms_next > slew_thr_reg) begin
            action_next = ntpoc_pkg::ACT_SLEW;
            slew_next   = ms_next[9:1];
        end else begin
            action_next = ntpoc_pkg::ACT_HOLD;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[8]) begin
            s8_action_reg <= action_next;
            s8_ahead_reg  <= s7_ok_reg && s7_ahead_reg;
            s8_secs_reg   <= s7_ok_reg ? s7_secs_reg : 32'd0;
            s8_ms_reg     <= s7_ok_reg ? ms_next : 10'd0;
            s8_est_reg    <= s7_ok_reg ? s7_est_reg : 64'd0;
            s8_slew_reg   <= slew_next;
        end
    end

    assign m_tdata = {2'b00, s8_slew_reg, s8_est_reg[31:0], s8_est_reg[63:32],
                      s8_ms_reg, s8_secs_reg, s8_ahead_reg, s8_action_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (s8_action_reg == ntpoc_pkg::ACT_REJECT) |->
            !s8_ahead_reg && (s8_secs_reg == 32'd0) && (s8_ms_reg == 10'd0) &&
            (s8_est_reg == 64'd0))
        else $error("rejected reply carries nonzero fields");

    a_slew_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (s8_action_reg != ntpoc_pkg::ACT_SLEW) |-> s8_slew_reg == 9'd0)
        else $error("slew amount set without a slew decision");

    a_ms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> s8_ms_reg <= 10'd1000)
        else $error("millisecond count out of range");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg) && !m_tready)
        else $error("input blocked while the pipeline has room");

endmodule
